@@ sv/srx_pkg.sv @@
// Shared types, codes and defaults of the stop-and-wait receiver.
`default_nettype none
package srx_pkg;

    localparam int SEQ_BITS_DEF    = 8;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int LEN_BYTES       = 4;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [31:0] CAPACITY_RESET = 32'd4096;

    // Configuration register word index.
    localparam logic [0:0] REG_CAPACITY = 1'b0;

    // Input action codes.
    localparam logic [1:0] ACT_BYTE     = 2'd0;
    localparam logic [1:0] ACT_TIMEOUT  = 2'd1;
    localparam logic [1:0] ACT_SYNC     = 2'd2;
    localparam logic [1:0] ACT_LINK_ERR = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_ACK      = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    // Error codes.
    localparam logic ERR_LINK  = 1'b0;
    localparam logic ERR_AHEAD = 1'b1;

    // Bit positions of the result mask, in delivery order.
    localparam int RES_ERR  = 0;
    localparam int RES_BYTE = 1;
    localparam int RES_ACK  = 2;
    localparam int RES_DONE = 3;
    localparam int RES_N    = 4;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] packet_byte;
        logic       packet_start;
        logic       packet_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [7:0]  ack_sequence;
        logic [31:0] delivered_count;
        logic        error_code;
        logic        last_in_run;
    } t_out_item;

    // All results caused by one input item, as handed from front to back.
    typedef struct packed {
        logic [RES_N-1:0] mask;
        logic             error_code;
        logic [7:0]       data_byte;
        logic [7:0]       ack_sequence;
        logic [31:0]      delivered_count;
    } t_bundle;

endpackage
`default_nettype wire

@@ sv/srx_front.sv @@
// Front part: protocol state, packet classification and result bundling.
`default_nettype none
module srx_front
    import srx_pkg::*;
#(
    parameter int SEQ_BITS = SEQ_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    input  t_in_item   i_item,
    input  wire        i_full,
    input  wire [31:0] i_capacity,
    output logic       o_stall,
    output logic       o_push,
    output t_bundle    o_bundle
);

    localparam logic [1:0] VERD_IDLE    = 2'd0;
    localparam logic [1:0] VERD_ACCEPT  = 2'd1;
    localparam logic [1:0] VERD_STALE   = 2'd2;
    localparam logic [1:0] VERD_DISCARD = 2'd3;

    logic [SEQ_BITS-1:0] r_expected, n_expected;
    logic [1:0]          r_verdict, n_verdict;
    logic [SEQ_BITS-1:0] r_pkt_seq, n_pkt_seq;
    logic                r_len_known, n_len_known;
    logic [2:0]          r_len_taken, n_len_taken;
    logic [31:0]         r_msg_len, n_msg_len;
    logic [31:0]         r_delivered, n_delivered;

    logic                accept;
    logic [15:0]         byte_ext;
    logic [SEQ_BITS-1:0] hdr;
    t_bundle             bundle;

    assign o_stall  = i_full;
    assign accept   = i_valid && !i_full;
    assign byte_ext = 16'(i_item.packet_byte);
    assign hdr      = byte_ext[SEQ_BITS-1:0];

    always_comb begin
        logic [15:0] seq_ext;
        n_expected  = r_expected;
        n_verdict   = r_verdict;
        n_pkt_seq   = r_pkt_seq;
        n_len_known = r_len_known;
        n_len_taken = r_len_taken;
        n_msg_len   = r_msg_len;
        n_delivered = r_delivered;
        bundle      = '0;
        seq_ext     = '0;
        if (accept) begin
            unique case (i_item.action)
                ACT_TIMEOUT, ACT_SYNC: begin
                end
                ACT_LINK_ERR: begin
                    n_len_known = 1'b0;
                    n_len_taken = '0;
                    n_msg_len   = '0;
                    n_delivered = '0;
                    n_verdict   = VERD_IDLE;
                    bundle.mask[RES_ERR] = 1'b1;
                    bundle.error_code    = ERR_LINK;
                end
                ACT_BYTE: begin
                    if (i_item.packet_start) begin
                        n_pkt_seq = hdr;
                        if (hdr == r_expected) begin
                            n_verdict = VERD_ACCEPT;
                        end else if (hdr < r_expected) begin
                            n_verdict = VERD_STALE;
                        end else begin
                            // Sender is ahead of us: the message is lost.
                            n_verdict   = VERD_DISCARD;
                            n_len_known = 1'b0;
                            n_len_taken = '0;
                            n_msg_len   = '0;
                            n_delivered = '0;
                            bundle.mask[RES_ERR] = 1'b1;
                            bundle.error_code    = ERR_AHEAD;
                        end
                    end else if (r_verdict == VERD_ACCEPT) begin
                        if (!r_len_known && r_len_taken < 3'(LEN_BYTES)) begin
                            n_msg_len   = r_msg_len | (32'(i_item.packet_byte)
                                          << {r_len_taken[1:0], 3'b000});
                            n_len_taken = 3'(r_len_taken + 3'd1);
                        end else if (r_delivered < i_capacity) begin
                            n_delivered = 32'(r_delivered + 32'd1);
                            bundle.mask[RES_BYTE] = 1'b1;
                            bundle.data_byte      = i_item.packet_byte;
                        end
                    end

                    if (i_item.packet_end && n_verdict != VERD_IDLE) begin
                        seq_ext = 16'(n_pkt_seq);
                        if (n_verdict == VERD_ACCEPT) begin
                            bundle.mask[RES_ACK] = 1'b1;
                            bundle.ack_sequence  = seq_ext[7:0];
                            n_expected  = SEQ_BITS'(r_expected + 1'b1);
                            n_len_known = 1'b1;
                            if (n_delivered >= n_msg_len || n_delivered >= i_capacity) begin
                                bundle.mask[RES_DONE]  = 1'b1;
                                bundle.delivered_count = n_delivered;
                                n_len_known = 1'b0;
                                n_len_taken = '0;
                                n_msg_len   = '0;
                                n_delivered = '0;
                            end
                        end else if (n_verdict == VERD_STALE) begin
                            bundle.mask[RES_ACK] = 1'b1;
                            bundle.ack_sequence  = seq_ext[7:0];
                        end
                        n_verdict = VERD_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_push   = accept && (bundle.mask != '0);
    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected  <= '0;
            r_verdict   <= VERD_IDLE;
            r_pkt_seq   <= '0;
            r_len_known <= 1'b0;
            r_len_taken <= '0;
            r_msg_len   <= '0;
            r_delivered <= '0;
        end else begin
            r_expected  <= n_expected;
            r_verdict   <= n_verdict;
            r_pkt_seq   <= n_pkt_seq;
            r_len_known <= n_len_known;
            r_len_taken <= n_len_taken;
            r_msg_len   <= n_msg_len;
            r_delivered <= n_delivered;
        end
    end

endmodule
`default_nettype wire

@@ sv/srx_queue.sv @@
// Short queue of result bundles between the front and back parts.
`default_nettype none
module srx_queue
    import srx_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_push,
    input  t_bundle i_wdata,
    input  wire     i_pop,
    output t_bundle o_rdata,
    output logic    o_empty,
    output logic    o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_bundle          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (i_pop && !i_push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/srx_back.sv @@
// Back part: unpacks each bundle into single result items on the output register.
`default_nettype none
module srx_back
    import srx_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_empty,
    input  t_bundle   i_head,
    output logic      o_pop,
    input  wire       i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    logic [RES_N-1:0] r_done;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic [RES_N-1:0] remaining;
    logic [RES_N-1:0] first;
    logic             last;
    logic             load;
    t_out_item        next_item;

    assign remaining = i_head.mask & ~r_done;
    assign first     = remaining & (~remaining + 1'b1);
    assign last      = (remaining == first);
    assign load      = !i_empty && (!r_out_valid || !i_out_stall);
    assign o_pop     = load && last;

    always_comb begin
        next_item             = '0;
        next_item.last_in_run = last;
        priority if (first[RES_ERR]) begin
            next_item.kind       = KIND_ERROR;
            next_item.error_code = i_head.error_code;
        end else if (first[RES_BYTE]) begin
            next_item.kind      = KIND_BYTE;
            next_item.data_byte = i_head.data_byte;
        end else if (first[RES_ACK]) begin
            next_item.kind         = KIND_ACK;
            next_item.ack_sequence = i_head.ack_sequence;
        end else begin
            next_item.kind            = KIND_COMPLETE;
            next_item.delivered_count = i_head.delivered_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_item <= next_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_done      <= last ? '0 : (r_done | first);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

@@ sv/stop_and_wait_receiver_top.sv @@
// Top level of the stop-and-wait receiver: configuration port and part wiring.
// A result item reaches the output through the queue and then the output register.
// Throughput: one input item per cycle while items cause at most one result each and the
// output does not stall; an item causing several results leaves them one per cycle.
// A queue of QUEUE_DEPTH result bundles absorbs such bursts before the input stalls.
// Reset (synchronous, active low) clears all protocol state and sets capacity to 4096.
`default_nettype none
module stop_and_wait_receiver_top
    import srx_pkg::*;
#(
    parameter int SEQ_BITS    = SEQ_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,

    input  wire                   i_in_valid,
    input  t_in_item              i_in_item,
    output logic                  o_in_stall,

    output logic                  o_out_valid,
    output t_out_item             o_out_item,
    input  wire                   i_out_stall,

    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [APB_ADDR_W-1:0] paddr,
    input  wire  [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // The single configuration register is the buffer capacity. Only the word
    // index bit of the address is decoded, so any byte offset within its word hits it.
    logic [31:0] r_capacity;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (cfg_write && paddr[2] == REG_CAPACITY) begin
            r_capacity <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? r_capacity : '0;

    // The front part classifies every accepted item in the cycle it arrives and
    // writes all of its results as one bundle into the queue. It stalls only
    // when the queue is full, which depends on registered state alone.
    logic    push;
    logic    pop;
    logic    q_empty;
    logic    q_full;
    t_bundle push_bundle;
    t_bundle head_bundle;

    srx_front #(
        .SEQ_BITS (SEQ_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_item     (i_in_item),
        .i_full     (q_full),
        .i_capacity (r_capacity),
        .o_stall    (o_in_stall),
        .o_push     (push),
        .o_bundle   (push_bundle)
    );

    srx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_bundle),
        .i_pop   (pop),
        .o_rdata (head_bundle),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // The back part walks each bundle in order (error, byte, ack, completion)
    // and loads one result item a cycle, unless the output stalls, into the output
    // register, marking the final one of each bundle.
    srx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (head_bundle),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench of the stop-and-wait receiver, with a predictor and random traffic.
`timescale 1ns / 1ps
module testbench;
    import srx_pkg::*;

    // The watchdog gives up after this many cycles in which no item moves on any port.
    // The longest legal quiet spell comes from the forced receiver hold-off.
    localparam int WATCHDOG_LIMIT = 1000;
    // Cycles to wait after the last result, enough for an item that causes no result
    // to leave the front part before the capacity register is touched.
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 12;
    localparam int HOLD_CYCLES    = 80;
    localparam int MAX_REPORTS    = 10;

    // Life of one packet as the receiver sees it.
    typedef enum logic [1:0] {
        PKT_IDLE,
        PKT_ACCEPT,
        PKT_STALE,
        PKT_DISCARD
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    logic      in_valid;
    t_in_item  in_item;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;
    logic      i_out_stall;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Items waiting for the driver, and the results the block still owes us.
    t_in_item  link_bytes[$];
    t_out_item due_results[$];

    int items_queued;
    int items_accepted;
    int failures;
    int quiet_cycles;

    // Pacing, set by the stimulus process and read by the driver and the monitor.
    int sender_idle_pct;
    int receiver_idle_pct;

    // The stimulus process asks for a hold-off by bumping hold_requests; the monitor
    // serves each request by stalling its side, counting the hold-off down in hold_left.
    int hold_requests;
    int holds_served;
    int hold_left;

    // Predictor state, a mirror of the receiver's protocol state.
    logic [7:0]  want_seq;
    logic [7:0]  open_seq;
    t_verdict    verdict;
    logic        len_known;
    logic [2:0]  len_taken;
    logic [31:0] msg_len;
    logic [31:0] delivered;
    logic [31:0] cap_bytes;

    // The sender's view of the sequence space, used to shape the traffic.
    logic [7:0] tx_seq;
    logic       seq_wrapped;

    stop_and_wait_receiver_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic t_out_item make_result(input logic [1:0] kind, input logic [7:0] data,
                                              input logic [7:0] ack, input logic [31:0] count,
                                              input logic err);
        t_out_item r;
        r.kind            = kind;
        r.data_byte       = data;
        r.ack_sequence    = ack;
        r.delivered_count = count;
        r.error_code      = err;
        r.last_in_run     = 1'b0;
        return r;
    endfunction

    // Forget the message in progress: length, length bytes and delivered count.
    function automatic void drop_message();
        len_known = 1'b0;
        len_taken = '0;
        msg_len   = '0;
        delivered = '0;
    endfunction

    // Advance the mirror by one accepted item and queue the results it causes.
    // Timeouts and out-of-sync events fall through without touching anything.
    function automatic void arq_step(input t_in_item it);
        t_out_item run[$];
        if (it.action == ACT_LINK_ERR) begin
            // A link error kills the message and any open packet; no ack goes out.
            drop_message();
            verdict = PKT_IDLE;
            run.push_back(make_result(KIND_ERROR, 8'h00, 8'h00, 32'd0, ERR_LINK));
        end else if (it.action == ACT_BYTE) begin
            if (it.packet_start) begin
                // A new header always replaces an open packet, which then gets no ack.
                open_seq = it.packet_byte;
                if (it.packet_byte == want_seq) begin
                    verdict = PKT_ACCEPT;
                end else if (it.packet_byte < want_seq) begin
                    verdict = PKT_STALE;
                end else begin
                    verdict = PKT_DISCARD;
                    drop_message();
                    run.push_back(make_result(KIND_ERROR, 8'h00, 8'h00, 32'd0, ERR_AHEAD));
                end
            end else if (verdict == PKT_ACCEPT) begin
                // The first payload bytes of a message carry its length, low byte first.
                if (!len_known && len_taken < LEN_BYTES) begin
                    msg_len   = msg_len | (32'(it.packet_byte) << (8 * len_taken));
                    len_taken = len_taken + 3'd1;
                end else if (delivered < cap_bytes) begin
                    delivered = delivered + 32'd1;
                    run.push_back(make_result(KIND_BYTE, it.packet_byte, 8'h00, 32'd0,
                                              ERR_LINK));
                end
            end
            if (it.packet_end && verdict != PKT_IDLE) begin
                if (verdict == PKT_ACCEPT) begin
                    run.push_back(make_result(KIND_ACK, 8'h00, open_seq, 32'd0, ERR_LINK));
                    want_seq  = want_seq + 8'd1;
                    len_known = 1'b1;
                    // A short first packet leaves missing length bytes at zero; the message
                    // completes here once its delivered count reaches that length or the capacity.
                    if (delivered >= msg_len || delivered >= cap_bytes) begin
                        run.push_back(make_result(KIND_COMPLETE, 8'h00, 8'h00, delivered,
                                                  ERR_LINK));
                        drop_message();
                    end
                end else if (verdict == PKT_STALE) begin
                    run.push_back(make_result(KIND_ACK, 8'h00, open_seq, 32'd0, ERR_LINK));
                end
                verdict = PKT_IDLE;
            end
        end
        if (run.size() != 0) begin
            run[run.size() - 1].last_in_run = 1'b1;
        end
        foreach (run[k]) begin
            due_results.push_back(run[k]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_item(input logic [1:0] act, input logic [7:0] b, input logic s,
                             input logic e);
        t_in_item it;
        it.action       = act;
        it.packet_byte  = b;
        it.packet_start = s;
        it.packet_end   = e;
        link_bytes.push_back(it);
        items_queued++;
    endtask

    // One packet: header, then body_len payload bytes. When small_length is set the
    // first four payload bytes spell a short message length, which only matters if
    // this turns out to be the first accepted packet of a message. Timeouts and
    // out-of-sync events are sprinkled in now and then; they must change nothing.
    task automatic queue_packet(input logic [7:0] header, input int body_len,
                                input bit closed, input bit small_length);
        logic [7:0] b;
        push_item(ACT_BYTE, header, 1'b1, closed && body_len == 0);
        for (int k = 0; k < body_len; k++) begin
            if ($urandom_range(99) < 5) begin
                push_item($urandom_range(1) ? ACT_TIMEOUT : ACT_SYNC, 8'($urandom),
                          1'($urandom), 1'($urandom));
            end
            if (small_length && k < LEN_BYTES) begin
                b = (k == 0) ? 8'($urandom_range(12)) : 8'h00;
            end else begin
                b = 8'($urandom);
            end
            push_item(ACT_BYTE, b, 1'b0, closed && k == body_len - 1);
        end
    endtask

    // One random scenario. Most are well-formed packets with the header the receiver
    // waits for; the rest are stale and early headers, cut packets, link errors,
    // stray bytes and idle events. With short_only set, every packet is a bare header
    // with no payload, and nearly every one carries the header the receiver
    // waits for, which walks the sequence number quickly.
    task automatic queue_scenario(input bit short_only);
        int pick;
        int body;
        int r;
        pick = $urandom_range(99);
        r    = $urandom_range(99);
        if (short_only) begin
            body = 0;
            if ($urandom_range(9) != 0) begin
                pick = 0;
            end
        end else if (r < 30) begin
            body = 0;
        end else if (r < 80) begin
            body = $urandom_range(6, 1);
        end else begin
            body = $urandom_range(14, 7);
        end
        if (pick < 62) begin
            if ($urandom_range(99) < 4) begin
                // Link failure in the middle of a good packet.
                queue_packet(tx_seq, body, 1'b0, 1'($urandom));
                push_item(ACT_LINK_ERR, 8'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                queue_packet(tx_seq, body, 1'b1, 1'($urandom));
                tx_seq = tx_seq + 8'd1;
                if (tx_seq == 8'd0) begin
                    seq_wrapped = 1'b1;
                end
            end
        end else if (pick < 70 && tx_seq != 8'd0) begin
            // Retransmission of a packet already acked.
            queue_packet(8'($urandom_range(tx_seq - 1)), body, 1'b1, 1'($urandom));
        end else if (pick < 78 && tx_seq != 8'hFF) begin
            // Header ahead of the expected one.
            queue_packet(8'($urandom_range(255, tx_seq + 1)), body, 1'b1, 1'($urandom));
        end else if (pick < 84) begin
            // Packet that never ends; the next header abandons it.
            queue_packet(8'($urandom), body, 1'b0, 1'($urandom));
        end else if (pick < 90) begin
            push_item(ACT_LINK_ERR, 8'($urandom), 1'($urandom), 1'($urandom));
        end else if (pick < 95) begin
            push_item(ACT_BYTE, 8'($urandom), 1'b0, 1'($urandom));
        end else begin
            push_item($urandom_range(1) ? ACT_TIMEOUT : ACT_SYNC, 8'($urandom),
                      1'($urandom), 1'($urandom));
        end
    endtask

    // Return once every queued item is accepted, every predicted result has come
    // back, and the pipeline had time to swallow items that cause no result.
    task automatic wait_drained();
        while (items_accepted != items_queued || due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the capacity over the configuration port while the block is idle, set
    // the pacing of both sides, and queue a batch of random scenarios.
    task automatic run_phase(input logic [31:0] capacity, input int send_idle,
                             input int recv_idle);
        int stop_at;
        wait_drained();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(REG_CAPACITY) << 2;
        pwdata  <= capacity;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        // The write landed at this edge.
        cap_bytes = capacity;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        sender_idle_pct   <= send_idle;
        receiver_idle_pct <= recv_idle;
        stop_at = items_queued + PHASE_ITEMS;
        while (items_queued < stop_at) begin
            queue_scenario(1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers items from link_bytes, holding each one until accepted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_link
        logic     nxt_valid;
        t_in_item nxt_item;
        nxt_valid = in_valid;
        nxt_item  = in_item;
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                arq_step(in_item);
                items_accepted++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && link_bytes.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct) begin
                nxt_item  = link_bytes.pop_front();
                nxt_valid = 1'b1;
            end
        end
        in_valid <= nxt_valid;
        in_item  <= nxt_item;
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest prediction and
    // drives the output stall, including the long hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_results
        t_out_item want;
        t_out_item got;
        logic      nxt_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = o_out_item;
            if (due_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("%0t: result with nothing predicted: kind %0d data %h ack %h",
                             $time, got.kind, got.data_byte, got.ack_sequence);
                end
            end else begin
                want = due_results.pop_front();
                if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                    got.ack_sequence !== want.ack_sequence ||
                    got.delivered_count !== want.delivered_count ||
                    got.error_code !== want.error_code ||
                    got.last_in_run !== want.last_in_run) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display({"%0t: mismatch (expected/actual) kind %0d/%0d ",
                                  "data %h/%h ack %h/%h count %0d/%0d err %0d/%0d ",
                                  "last %0d/%0d"}, $time,
                                 want.kind, got.kind, want.data_byte, got.data_byte,
                                 want.ack_sequence, got.ack_sequence,
                                 want.delivered_count, got.delivered_count,
                                 want.error_code, got.error_code,
                                 want.last_in_run, got.last_in_run);
                    end
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            nxt_stall = 1'b1;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            nxt_stall = 1'b1;
        end else begin
            nxt_stall = ($urandom_range(99) < receiver_idle_pct);
        end
        i_out_stall <= nxt_stall;
    end

    // Watchdog: a run that stops moving items is a failure.
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        in_valid          = 1'b0;
        in_item           = '0;
        i_out_stall       = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        i_rst_n           = 1'b0;
        items_queued      = 0;
        items_accepted    = 0;
        failures          = 0;
        quiet_cycles      = 0;
        sender_idle_pct   = 36;
        receiver_idle_pct = 64;
        hold_requests     = 0;
        holds_served      = 0;
        hold_left         = 0;

        // State after reset, capacity at its reset value.
        want_seq  = '0;
        open_seq  = '0;
        verdict   = PKT_IDLE;
        cap_bytes = CAPACITY_RESET;
        drop_message();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, at the reset capacity and with the pacing of the first
        // random phases. Idle events, even with framing bits set, do nothing.
        push_item(ACT_TIMEOUT, 8'hFF, 1'b1, 1'b1);
        push_item(ACT_SYNC,    8'h00, 1'b0, 1'b0);
        // A payload byte with no packet open is ignored.
        push_item(ACT_BYTE,    8'hAA, 1'b0, 1'b0);
        // Packet 0 declares a two-byte message; its last byte yields a byte, the
        // ack and the completion, three results from one item.
        push_item(ACT_BYTE,    8'h00, 1'b1, 1'b0);
        push_item(ACT_BYTE,    8'h02, 1'b0, 1'b0);
        push_item(ACT_BYTE,    8'h00, 1'b0, 1'b0);
        push_item(ACT_BYTE,    8'h00, 1'b0, 1'b0);
        push_item(ACT_BYTE,    8'h00, 1'b0, 1'b0);
        push_item(ACT_BYTE,    8'hFF, 1'b0, 1'b0);
        push_item(ACT_TIMEOUT, 8'h00, 1'b0, 1'b0);
        push_item(ACT_BYTE,    8'h00, 1'b0, 1'b1);
        // Header and end on one byte: empty first packet, length zero, completes.
        push_item(ACT_BYTE,    8'h01, 1'b1, 1'b1);
        // Retransmission of packet 0 is acked again.
        push_item(ACT_BYTE,    8'h00, 1'b1, 1'b0);
        push_item(ACT_BYTE,    8'h77, 1'b0, 1'b1);
        // Packet 2 is cut off by a fresh header 2, which is then acked while its
        // message stays open.
        push_item(ACT_BYTE,    8'h02, 1'b1, 1'b0);
        push_item(ACT_BYTE,    8'h05, 1'b0, 1'b0);
        push_item(ACT_BYTE,    8'h02, 1'b1, 1'b0);
        push_item(ACT_BYTE,    8'h03, 1'b0, 1'b0);
        push_item(ACT_BYTE,    8'h00, 1'b0, 1'b1);
        // Header far ahead: error, the rest of the packet is thrown away.
        push_item(ACT_BYTE,    8'hFF, 1'b1, 1'b0);
        push_item(ACT_BYTE,    8'h11, 1'b0, 1'b1);
        // Link failure, then an empty packet 3 starting a new message.
        push_item(ACT_LINK_ERR, 8'h80, 1'b1, 1'b1);
        push_item(ACT_BYTE,    8'h03, 1'b1, 1'b1);
        tx_seq      = 8'd4;
        seq_wrapped = 1'b0;

        // Random part. The first two phases idle the sender lightly and the receiver
        // heavily, the next two the other way round, and the last one runs flat out.
        run_phase(32'd0,          36, 64);
        run_phase(32'd5,          36, 64);
        run_phase(32'hFFFF_FFFF,  64, 36);
        run_phase(32'd2,          64, 36);
        run_phase(CAPACITY_RESET,  0,  0);

        // With items streaming in at full rate, hold the output side off long enough
        // for the result queue to fill and push back on the input.
        hold_requests <= hold_requests + 1;

        // Keep going until the sequence number has wrapped past 255.
        while (!seq_wrapped) begin
            queue_scenario(1'b1);
        end

        wait_drained();
        if (failures == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

@@ stop_and_wait_receiver_top.f @@
sv/srx_pkg.sv
sv/srx_front.sv
sv/srx_queue.sv
sv/srx_back.sv
sv/stop_and_wait_receiver_top.sv
sim/testbench.sv
